// ----- design/bzf_pkg.sv -----
// Shared types and constants for the cubic Bezier flattener.
package bzf_pkg;

  localparam logic [15:0] STEP_MIN   = 16'd1057;
  localparam logic [15:0] STEP_RESET = 16'd6554;

  localparam logic KIND_POS = 1'b0;
  localparam logic KIND_SEG = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_MUL,
    ST_EMIT,
    ST_END
  } state_t;

  typedef enum logic [3:0] {
    OP_ABX,
    OP_BCX,
    OP_CDX,
    OP_ABY,
    OP_BCY,
    OP_CDY,
    OP_ABCX,
    OP_BCDX,
    OP_ABCY,
    OP_BCDY,
    OP_PX,
    OP_PY
  } lerp_op_t;

  typedef struct packed {
    lerp_op_t op;
    logic     load_seg;
    logic     load_pos;
    logic     write;
    logic     emit_pt;
    logic     emit_end;
  } ctl_t;

endpackage

// ----- design/bzf_lerp.sv -----
// Shared fixed-point interpolator: y = a + round((b - a) * t / 65536), one register stage.
module bzf_lerp (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic        [15:0] t,
  output logic signed [31:0] y
);

  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [49:0] prod_q;
  logic signed [31:0] a_q;
  logic signed [49:0] rounded;

  assign diff = {b[31], b} - {a[31], a};
  assign prod = diff * $signed({1'b0, t});

  always_ff @(posedge clk) begin
    prod_q <= prod;
    a_q    <= a;
  end

  assign rounded = prod_q + 50'sd32768;
  assign y       = a_q + rounded[47:16];

endmodule

// ----- design/bzf_ctrl.sv -----
// Sequencer: walks t and the twelve interpolations of each curve point.
module bzf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          kind,
  input  logic          slot_free,
  input  logic [15:0]   step_size,
  output logic          in_stall,
  output logic [15:0]   t,
  output bzf_pkg::ctl_t ctl
);

  bzf_pkg::state_t   state;
  bzf_pkg::state_t   state_next;
  bzf_pkg::lerp_op_t op;
  logic [15:0]       step_eff;
  logic [16:0]       t_sum;

  assign step_eff = (step_size < bzf_pkg::STEP_MIN) ? bzf_pkg::STEP_MIN : step_size;
  assign t_sum    = {1'b0, t} + {1'b0, step_eff};

  always_comb begin
    state_next = state;
    case (state)
      bzf_pkg::ST_IDLE: begin
        if (in_valid && kind == bzf_pkg::KIND_SEG) state_next = bzf_pkg::ST_ISSUE;
      end
      bzf_pkg::ST_ISSUE: state_next = bzf_pkg::ST_MUL;
      bzf_pkg::ST_MUL: begin
        state_next = (op == bzf_pkg::OP_PY) ? bzf_pkg::ST_EMIT : bzf_pkg::ST_ISSUE;
      end
      bzf_pkg::ST_EMIT: begin
        if (slot_free) state_next = t_sum[16] ? bzf_pkg::ST_END : bzf_pkg::ST_ISSUE;
      end
      bzf_pkg::ST_END: begin
        if (slot_free) state_next = bzf_pkg::ST_IDLE;
      end
      default: state_next = bzf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != bzf_pkg::ST_IDLE);
    ctl          = '0;
    ctl.op       = op;
    ctl.load_seg = (state == bzf_pkg::ST_IDLE) && in_valid && (kind == bzf_pkg::KIND_SEG);
    ctl.load_pos = (state == bzf_pkg::ST_IDLE) && in_valid && (kind == bzf_pkg::KIND_POS);
    ctl.write    = (state == bzf_pkg::ST_MUL);
    ctl.emit_pt  = (state == bzf_pkg::ST_EMIT) && slot_free;
    ctl.emit_end = (state == bzf_pkg::ST_END) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bzf_pkg::ST_IDLE;
      op    <= bzf_pkg::OP_ABX;
      t     <= '0;
    end else begin
      state <= state_next;
      if (ctl.load_seg) begin
        op <= bzf_pkg::OP_ABX;
        t  <= '0;
      end else if (state == bzf_pkg::ST_MUL && op != bzf_pkg::OP_PY) begin
        op <= bzf_pkg::lerp_op_t'(op + 4'd1);
      end else if (ctl.emit_pt) begin
        op <= bzf_pkg::OP_ABX;
        t  <= t_sum[15:0];
      end
    end
  end

  a_issue_then_mul: assert property (@(posedge clk) disable iff (rst)
    state == bzf_pkg::ST_ISSUE |=> state == bzf_pkg::ST_MUL)
    else $error("interpolation issue not followed by accumulate");

  a_seg_start: assert property (@(posedge clk) disable iff (rst)
    ctl.load_seg |=> (t == 16'd0 && op == bzf_pkg::OP_ABX && state == bzf_pkg::ST_ISSUE))
    else $error("segment did not start at t = 0");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit_pt || ctl.emit_end) |-> (slot_free && !ctl.write))
    else $error("item emitted into a busy output slot");

  a_op_step: assert property (@(posedge clk) disable iff (rst)
    (state == bzf_pkg::ST_MUL && op != bzf_pkg::OP_PY)
      |=> op == bzf_pkg::lerp_op_t'($past(op) + 4'd1))
    else $error("interpolation order skipped");

endmodule

// ----- design/cubic_bezier_flattener_unit.sv -----
// Top level of the cubic Bezier flattener: operand registers, operand select and output slot.
//
// Input channel (in_valid / in_stall) takes one item: kind, two control points and an end
// point, Q16.16. A position item (kind 0) loads the start point and emits nothing.
// A segment item (kind 1) emits curve points at t = 0, step, 2*step ... while t < 1, then
// the end point with last set; the end point becomes the next start.
// Each curve point takes the twelve interpolations in the shared interpolator, each a multiply
// (ISSUE state), then a round and add (MUL state); the EMIT state then loads the output slot.
// At the reset step (about 0.1) a segment has n = 10 curve points. in_stall is high from the
// acceptance of a segment until its end point is loaded into the output slot.
// Output channel (out_valid / out_stall) is a single register slot; while the receiver
// stalls, the sequencer waits with the next point held ready and resumes when it is taken.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes step_size, unsigned Q0.16; steps
// below 1057 act as 1057. It is always ready; the user must write it only while the block is
// idle, as the block does not enforce this. Reset (rst, synchronous) empties the output slot,
// sets step_size to 6554 and the start point to zero.
module cubic_bezier_flattener_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [15:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [31:0] ctrl1_x,
  input  logic signed [31:0] ctrl1_y,
  input  logic signed [31:0] ctrl2_x,
  input  logic signed [31:0] ctrl2_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic               last
);

  bzf_pkg::ctl_t      ctl;
  logic        [15:0] step_size;
  logic        [15:0] t;
  logic               slot_free;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [31:0] lerp_y;

  logic signed [31:0] start_x, start_y;
  logic signed [31:0] c1x, c1y, c2x, c2y, ex, ey;
  logic signed [31:0] abx, bcx, cdx, aby, bcy, cdy;
  logic signed [31:0] abcx, bcdx, abcy, bcdy, curve_x, curve_y;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= bzf_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_size <= cfg_data;
    end
  end

  bzf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .slot_free (slot_free),
    .step_size (step_size),
    .in_stall  (in_stall),
    .t         (t),
    .ctl       (ctl)
  );

  always_comb begin
    case (ctl.op)
      bzf_pkg::OP_ABX:  begin opa = start_x; opb = c1x;  end
      bzf_pkg::OP_BCX:  begin opa = c1x;     opb = c2x;  end
      bzf_pkg::OP_CDX:  begin opa = c2x;     opb = ex;   end
      bzf_pkg::OP_ABY:  begin opa = start_y; opb = c1y;  end
      bzf_pkg::OP_BCY:  begin opa = c1y;     opb = c2y;  end
      bzf_pkg::OP_CDY:  begin opa = c2y;     opb = ey;   end
      bzf_pkg::OP_ABCX: begin opa = abx;     opb = bcx;  end
      bzf_pkg::OP_BCDX: begin opa = bcx;     opb = cdx;  end
      bzf_pkg::OP_ABCY: begin opa = aby;     opb = bcy;  end
      bzf_pkg::OP_BCDY: begin opa = bcy;     opb = cdy;  end
      bzf_pkg::OP_PX:   begin opa = abcx;    opb = bcdx; end
      bzf_pkg::OP_PY:   begin opa = abcy;    opb = bcdy; end
      default:          begin opa = abcy;    opb = bcdy; end
    endcase
  end

  bzf_lerp u_lerp (
    .clk (clk),
    .a   (opa),
    .b   (opb),
    .t   (t),
    .y   (lerp_y)
  );

  always_ff @(posedge clk) begin
    if (ctl.load_seg) begin
      c1x <= ctrl1_x;
      c1y <= ctrl1_y;
      c2x <= ctrl2_x;
      c2y <= ctrl2_y;
      ex  <= end_x;
      ey  <= end_y;
    end
    if (ctl.write) begin
      case (ctl.op)
        bzf_pkg::OP_ABX:  abx     <= lerp_y;
        bzf_pkg::OP_BCX:  bcx     <= lerp_y;
        bzf_pkg::OP_CDX:  cdx     <= lerp_y;
        bzf_pkg::OP_ABY:  aby     <= lerp_y;
        bzf_pkg::OP_BCY:  bcy     <= lerp_y;
        bzf_pkg::OP_CDY:  cdy     <= lerp_y;
        bzf_pkg::OP_ABCX: abcx    <= lerp_y;
        bzf_pkg::OP_BCDX: bcdx    <= lerp_y;
        bzf_pkg::OP_ABCY: abcy    <= lerp_y;
        bzf_pkg::OP_BCDY: bcdy    <= lerp_y;
        bzf_pkg::OP_PX:   curve_x <= lerp_y;
        bzf_pkg::OP_PY:   curve_y <= lerp_y;
        default:          curve_y <= lerp_y;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
    end else if (ctl.load_pos) begin
      start_x <= end_x;
      start_y <= end_y;
    end else if (ctl.emit_end) begin
      start_x <= ex;
      start_y <= ey;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_pt || ctl.emit_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_pt) begin
      point_x <= curve_x;
      point_y <= curve_y;
      last    <= 1'b0;
    end else if (ctl.emit_end) begin
      point_x <= ex;
      point_y <= ey;
      last    <= 1'b1;
    end
  end

endmodule

// ----- tb/cubic_bezier_flattener_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_flattener_unit: path items against a curve predictor.
module cubic_bezier_flattener_unit_test;

  localparam int T_UNIT         = 65536;
  localparam int MAX_CURVE_PTS  = 63;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_PHASES       = 10;

  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;

  typedef struct {
    logic               kind;
    logic signed [31:0] c1x;
    logic signed [31:0] c1y;
    logic signed [31:0] c2x;
    logic signed [31:0] c2y;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } path_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } plot_point_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [15:0] cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               kind      = bzf_pkg::KIND_POS;
  logic signed [31:0] ctrl1_x   = '0;
  logic signed [31:0] ctrl1_y   = '0;
  logic signed [31:0] ctrl2_x   = '0;
  logic signed [31:0] ctrl2_y   = '0;
  logic signed [31:0] end_x     = '0;
  logic signed [31:0] end_y     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last;

  path_item_t         path_items[$];
  plot_point_t        pending_points[$];
  path_item_t         shown;
  logic        [15:0] step_cfg = bzf_pkg::STEP_RESET;
  logic signed [31:0] pen_x = '0;
  logic signed [31:0] pen_y = '0;
  int                 max_gap = 8;
  int                 max_stall = 8;
  int                 in_gap = 0;
  int                 stall_left = 0;
  int                 n_queued = 0;
  int                 n_taken = 0;
  int                 n_errors = 0;
  int                 quiet_cycles = 0;

  cubic_bezier_flattener_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .ctrl1_x   (ctrl1_x),
    .ctrl1_y   (ctrl1_y),
    .ctrl2_x   (ctrl2_x),
    .ctrl2_y   (ctrl2_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // round-to-nearest blend, halves up: floor(a*(1-t) + b*t + 0.5) in Q16
  function automatic logic signed [31:0] interp(input logic signed [31:0] a,
                                                input logic signed [31:0] b, input int t);
    longint acc;
    acc = longint'(a) * longint'(T_UNIT - t) + longint'(b) * longint'(t) + 64'sd32768;
    return acc[47:16];
  endfunction

  task automatic flatten_item(input path_item_t it);
    int t;
    int n;
    int step;
    logic signed [31:0] abx, aby, bcx, bcy, cdx, cdy;
    if (it.kind == bzf_pkg::KIND_SEG) begin
      step = (step_cfg < bzf_pkg::STEP_MIN) ? int'(bzf_pkg::STEP_MIN) : int'(step_cfg);
      t = 0;
      n = 0;
      while (t < T_UNIT && n < MAX_CURVE_PTS) begin
        abx = interp(pen_x, it.c1x, t);
        aby = interp(pen_y, it.c1y, t);
        bcx = interp(it.c1x, it.c2x, t);
        bcy = interp(it.c1y, it.c2y, t);
        cdx = interp(it.c2x, it.ex, t);
        cdy = interp(it.c2y, it.ey, t);
        pending_points.push_back('{interp(interp(abx, bcx, t), interp(bcx, cdx, t), t),
                                   interp(interp(aby, bcy, t), interp(bcy, cdy, t), t),
                                   1'b0});
        t += step;
        n++;
      end
      pending_points.push_back('{it.ex, it.ey, 1'b1});
    end
    pen_x = it.ex;
    pen_y = it.ey;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        flatten_item(shown);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (path_items.size() != 0) begin
          shown = path_items.pop_front();
          kind     <= shown.kind;
          ctrl1_x  <= shown.c1x;
          ctrl1_y  <= shown.c1y;
          ctrl2_x  <= shown.c2x;
          ctrl2_y  <= shown.c2y;
          end_x    <= shown.ex;
          end_y    <= shown.ey;
          in_valid <= 1'b1;
          in_gap = $urandom_range(0, max_gap);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    plot_point_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point (%0d, %0d) last %0b", point_x, point_y, last);
        n_errors++;
      end else begin
        want = pending_points.pop_front();
        if (point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, point_x);
          n_errors++;
        end
        if (point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, point_y);
          n_errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          n_errors++;
        end
      end
      stall_left = $urandom_range(0, max_stall);
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("cubic_bezier_flattener_unit_test: FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return CMAX - $urandom_range(0, 3);
      1:       return CMIN + $urandom_range(0, 3);
      2, 3:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic k, input logic signed [31:0] a, b, c, d, e, f);
    path_items.push_back('{k, a, b, c, d, e, f});
    n_queued++;
  endtask

  task automatic add_random_item();
    logic k;
    k = ($urandom_range(0, 4) == 0) ? bzf_pkg::KIND_POS : bzf_pkg::KIND_SEG;
    add_item(k, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord());
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_taken != n_queued || pending_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    step_cfg = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : sequencer
    logic [15:0] step_plan [N_PHASES];
    int count;
    step_plan[0] = bzf_pkg::STEP_MIN;
    step_plan[1] = 16'hFFFF;
    step_plan[2] = 16'd0;
    step_plan[3] = bzf_pkg::STEP_MIN - 16'd1;
    step_plan[4] = 16'h8000;
    step_plan[5] = 16'($urandom_range(int'(bzf_pkg::STEP_MIN), 65535));
    step_plan[6] = 16'($urandom_range(int'(bzf_pkg::STEP_MIN), 65535));
    step_plan[7] = 16'($urandom_range(int'(bzf_pkg::STEP_MIN), 65535));
    step_plan[8] = 16'($urandom_range(0, 65535));
    step_plan[9] = bzf_pkg::STEP_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // first segment starts from the reset origin
    add_item(bzf_pkg::KIND_SEG, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
             -32'sh0001_0000, 32'sh0004_0000, 32'sh0000_8000);
    add_item(bzf_pkg::KIND_POS, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX);
    add_item(bzf_pkg::KIND_SEG, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    add_item(bzf_pkg::KIND_POS, 0, 0, 0, 0, CMIN, CMIN);
    add_item(bzf_pkg::KIND_SEG, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    add_item(bzf_pkg::KIND_SEG, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
    add_item(bzf_pkg::KIND_SEG, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX);
    add_item(bzf_pkg::KIND_SEG, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN);
    add_item(bzf_pkg::KIND_POS, CMIN, CMAX, 32'sh1234_5678, -1, 0, 0);
    add_item(bzf_pkg::KIND_POS, 0, 0, 0, 0, 1, -1);
    add_item(bzf_pkg::KIND_SEG, 0, 0, 0, 0, 0, 0);
    add_item(bzf_pkg::KIND_SEG, 1, -1, -1, 1, 2, -2);
    add_item(bzf_pkg::KIND_SEG, 32'sh0000_8000, -32'sh0000_8000, 3, -3, -1, 1);
    add_item(bzf_pkg::KIND_SEG, 0, 0, 0, 0, 0, 0);
    wait_idle();

    for (int phase = 0; phase < N_PHASES; phase++) begin
      max_gap   = (phase % 3 == 2) ? 0 : 8;
      max_stall = (phase % 4 == 3) ? 0 : 8;
      write_step(step_plan[phase]);
      count = (step_plan[phase] <= 16'd2000) ? 12 : 55;
      repeat (count) add_random_item();
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("cubic_bezier_flattener_unit_test: PASS");
    end else begin
      $display("cubic_bezier_flattener_unit_test: FAIL");
    end
    $finish;
  end

endmodule
